// ===== rtl/sorted_site_window_clusterer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: assertion macros
// Concurrent assertion shorthands, clocked on a rising edge and disabled in
// reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SITE_WINDOW_CLUSTERER_TOP_ASSERT_SVH
`define SORTED_SITE_WINDOW_CLUSTERER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SSWC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSWC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sswc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: package
// Shared widths, register indexes, reset values, codes and types.
// ----------------------------------------------------------------------------
package sswc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CHROM_WIDTH_DEF = 8;
	localparam int POS_WIDTH       = 32;
	localparam int WINDOW_WIDTH    = 20;
	localparam int THRESH_WIDTH    = 16;
	localparam int CFG_DATA_WIDTH  = 20;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CLASS_WIDTH     = 2;

	// Per-site counts, kept as one array
	localparam int NUM_COUNTS      = 6;
	localparam int CNT_LEFT_CLIP   = 0;
	localparam int CNT_RIGHT_CLIP  = 1;
	localparam int CNT_LEFT_DISC   = 2;
	localparam int CNT_RIGHT_DISC  = 3;
	localparam int CNT_LEFT_POLYA  = 4;
	localparam int CNT_RIGHT_POLYA = 5;

	typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

	localparam cfg_index_t REG_CLUSTER_WINDOW = 3'd0;
	localparam cfg_index_t REG_ENTRY_MIN_CLIP = 3'd1;
	localparam cfg_index_t REG_ENTRY_MIN_DISC = 3'd2;
	localparam cfg_index_t REG_KEEP_MIN_CLIP  = 3'd3;
	localparam cfg_index_t REG_KEEP_MIN_DISC  = 3'd4;

	localparam logic [WINDOW_WIDTH-1:0] CLUSTER_WINDOW_RST = 20'd100;
	localparam logic [THRESH_WIDTH-1:0] ENTRY_MIN_CLIP_RST = 16'd1;
	localparam logic [THRESH_WIDTH-1:0] ENTRY_MIN_DISC_RST = 16'd1;
	localparam logic [THRESH_WIDTH-1:0] KEEP_MIN_CLIP_RST  = 16'd2;
	localparam logic [THRESH_WIDTH-1:0] KEEP_MIN_DISC_RST  = 16'd1;

	localparam logic OP_SITE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef logic [CLASS_WIDTH-1:0] support_class_t;

	localparam support_class_t CLASS_TWO_SIDE = 2'd0;
	localparam support_class_t CLASS_ONE_HALF = 2'd1;
	localparam support_class_t CLASS_ONE_SIDE = 2'd2;
	localparam support_class_t CLASS_OTHER    = 2'd3;

	typedef struct packed {
		logic [WINDOW_WIDTH-1:0] chain_window;
		logic [THRESH_WIDTH-1:0] entry_min_clip;
		logic [THRESH_WIDTH-1:0] entry_min_disc;
		logic [THRESH_WIDTH-1:0] keep_min_clip;
		logic [THRESH_WIDTH-1:0] keep_min_disc;
	} cfg_t;

endpackage

// ===== rtl/sswc_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: stream interfaces
// Valid/ready channels for evidence sites in and cluster results out.
// ----------------------------------------------------------------------------
interface sswc_site_if
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic [CHROM_WIDTH-1:0] chromosome;
	logic [POS_WIDTH-1:0]   position;
	logic [COUNT_WIDTH-1:0] left_clip;
	logic [COUNT_WIDTH-1:0] right_clip;
	logic [COUNT_WIDTH-1:0] left_disc;
	logic [COUNT_WIDTH-1:0] right_disc;
	logic [COUNT_WIDTH-1:0] polya_left;
	logic [COUNT_WIDTH-1:0] polya_right;

	modport source (
		output valid, operation, chromosome, position, left_clip, right_clip,
		       left_disc, right_disc, polya_left, polya_right,
		input  ready
	);
	modport sink (
		input  valid, operation, chromosome, position, left_clip, right_clip,
		       left_disc, right_disc, polya_left, polya_right,
		output ready
	);
endinterface

interface sswc_cluster_if
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [CHROM_WIDTH-1:0] out_chromosome;
	logic [POS_WIDTH-1:0]   rep_position;
	logic [COUNT_WIDTH-1:0] left_clip_total;
	logic [COUNT_WIDTH-1:0] right_clip_total;
	logic [COUNT_WIDTH-1:0] left_disc_total;
	logic [COUNT_WIDTH-1:0] right_disc_total;
	logic [COUNT_WIDTH:0]   polya_total;
	logic [CLASS_WIDTH-1:0] support_class;

	modport source (
		output valid, out_chromosome, rep_position, left_clip_total,
		       right_clip_total, left_disc_total, right_disc_total,
		       polya_total, support_class,
		input  ready
	);
	modport sink (
		input  valid, out_chromosome, rep_position, left_clip_total,
		       right_clip_total, left_disc_total, right_disc_total,
		       polya_total, support_class,
		output ready
	);
endinterface

// ===== rtl/sswc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: configuration registers
// Write-only register file for the window and threshold settings.
// ----------------------------------------------------------------------------
module sswc_cfg_regs
	import sswc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  cfg_index_t                wr_index,
	input  logic [CFG_DATA_WIDTH-1:0] wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chain_window   <= CLUSTER_WINDOW_RST;
			cfg_q.entry_min_clip <= ENTRY_MIN_CLIP_RST;
			cfg_q.entry_min_disc <= ENTRY_MIN_DISC_RST;
			cfg_q.keep_min_clip  <= KEEP_MIN_CLIP_RST;
			cfg_q.keep_min_disc  <= KEEP_MIN_DISC_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CLUSTER_WINDOW: cfg_q.chain_window   <= wr_data[WINDOW_WIDTH-1:0];
				REG_ENTRY_MIN_CLIP: cfg_q.entry_min_clip <= wr_data[THRESH_WIDTH-1:0];
				REG_ENTRY_MIN_DISC: cfg_q.entry_min_disc <= wr_data[THRESH_WIDTH-1:0];
				REG_KEEP_MIN_CLIP:  cfg_q.keep_min_clip  <= wr_data[THRESH_WIDTH-1:0];
				REG_KEEP_MIN_DISC:  cfg_q.keep_min_disc  <= wr_data[THRESH_WIDTH-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sswc_site_stage.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: input stage
// Input register; adds the site's clip and discordant pairs on the way in,
// registering the admission flag and the evidence score.
// ----------------------------------------------------------------------------
module sswc_site_stage
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [CHROM_WIDTH-1:0] chromosome,
	input  logic [POS_WIDTH-1:0]   position,
	input  logic [COUNT_WIDTH-1:0] cnt [NUM_COUNTS],
	input  logic                   advance,
	output logic                   valid_s1,
	output logic                   flush_s1,
	output logic                   admit_s1,
	output logic [CHROM_WIDTH-1:0] chrom_s1,
	output logic [POS_WIDTH-1:0]   pos_s1,
	output logic [COUNT_WIDTH-1:0] cnt_s1 [NUM_COUNTS],
	output logic [COUNT_WIDTH+1:0] evidence_s1
);

	localparam int PAIR_W = COUNT_WIDTH + 1;
	localparam int CMP_W  = (PAIR_W > THRESH_WIDTH) ? PAIR_W : THRESH_WIDTH;
	localparam int EV_W   = COUNT_WIDTH + 2;

	logic [PAIR_W-1:0] clip_pair;
	logic [PAIR_W-1:0] disc_pair;
	logic              admit;
	logic [EV_W-1:0]   evidence;

	assign clip_pair = {1'b0, cnt[CNT_LEFT_CLIP]} + {1'b0, cnt[CNT_RIGHT_CLIP]};
	assign disc_pair = {1'b0, cnt[CNT_LEFT_DISC]} + {1'b0, cnt[CNT_RIGHT_DISC]};
	assign admit     = (CMP_W'(clip_pair) >= CMP_W'(cfg.entry_min_clip)) ||
	                   (CMP_W'(disc_pair) >= CMP_W'(cfg.entry_min_disc));
	assign evidence  = EV_W'(clip_pair) + EV_W'(disc_pair);

	// take a new site whenever the stage is empty or its item moves on
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			flush_s1    <= (operation == OP_FLUSH);
			admit_s1    <= admit;
			chrom_s1    <= chromosome;
			pos_s1      <= position;
			cnt_s1      <= cnt;
			evidence_s1 <= evidence;
		end
	end

endmodule

// ===== rtl/sswc_cluster_core.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: cluster core
// Open-cluster state, window chaining, saturating sums, best-site tracking,
// and the close/keep/classify logic feeding the result register.
// ----------------------------------------------------------------------------
module sswc_cluster_core
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   fire,
	input  logic                   flush_s1,
	input  logic                   admit_s1,
	input  logic [CHROM_WIDTH-1:0] chrom_s1,
	input  logic [POS_WIDTH-1:0]   pos_s1,
	input  logic [COUNT_WIDTH-1:0] cnt_s1 [NUM_COUNTS],
	input  logic [COUNT_WIDTH+1:0] evidence_s1,
	output logic                   res_valid,
	output logic [CHROM_WIDTH-1:0] res_chrom,
	output logic [POS_WIDTH-1:0]   res_position,
	output logic [COUNT_WIDTH-1:0] res_sum [NUM_COUNTS-2],
	output logic [COUNT_WIDTH:0]   res_polya,
	output support_class_t         res_class
);

	localparam int PAIR_W = COUNT_WIDTH + 1;
	localparam int CMP_W  = (PAIR_W > THRESH_WIDTH) ? PAIR_W : THRESH_WIDTH;
	localparam int EV_W   = COUNT_WIDTH + 2;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
	endfunction

	logic                   open_q;
	logic [CHROM_WIDTH-1:0] chrom_q;
	logic [POS_WIDTH-1:0]   last_pos_q;
	logic [POS_WIDTH-1:0]   best_pos_q;
	logic [EV_W-1:0]        best_ev_q;
	logic [COUNT_WIDTH-1:0] sum_q   [NUM_COUNTS];
	logic [COUNT_WIDTH-1:0] sum_sat [NUM_COUNTS];

	logic [POS_WIDTH:0]     gap;
	logic                   in_window;
	logic                   chain;
	logic                   do_close;
	logic [PAIR_W-1:0]      clip_tot;
	logic [PAIR_W-1:0]      disc_tot;
	logic                   keep;
	logic                   left_hit;
	logic                   right_hit;
	logic                   crossed;

	// borrow out of the gap means the position went backward
	assign gap       = {1'b0, pos_s1} - {1'b0, last_pos_q};
	assign in_window = !gap[POS_WIDTH] &&
	                   (gap[POS_WIDTH-1:0] <= POS_WIDTH'(cfg.chain_window));
	assign chain     = open_q && (chrom_s1 == chrom_q) && in_window;
	assign do_close  = flush_s1 || (admit_s1 && !chain);

	assign clip_tot = {1'b0, sum_q[CNT_LEFT_CLIP]} + {1'b0, sum_q[CNT_RIGHT_CLIP]};
	assign disc_tot = {1'b0, sum_q[CNT_LEFT_DISC]} + {1'b0, sum_q[CNT_RIGHT_DISC]};
	assign keep     = (CMP_W'(clip_tot) >= CMP_W'(cfg.keep_min_clip)) ||
	                  (CMP_W'(disc_tot) >= CMP_W'(cfg.keep_min_disc));

	assign res_valid = fire && do_close && open_q && keep;

	for (genvar i = 0; i < NUM_COUNTS; i++) begin : g_sum
		assign sum_sat[i] = sat_add(sum_q[i], cnt_s1[i]);
	end

	for (genvar i = 0; i < NUM_COUNTS - 2; i++) begin : g_res
		assign res_sum[i] = sum_q[i];
	end

	assign res_chrom    = chrom_q;
	assign res_position = best_pos_q;
	assign res_polya    = {1'b0, sum_q[CNT_LEFT_POLYA]} + {1'b0, sum_q[CNT_RIGHT_POLYA]};

	assign left_hit  = (|sum_q[CNT_LEFT_CLIP]) || (|sum_q[CNT_LEFT_DISC]);
	assign right_hit = (|sum_q[CNT_RIGHT_CLIP]) || (|sum_q[CNT_RIGHT_DISC]);
	assign crossed   = ((|sum_q[CNT_LEFT_CLIP]) && (|sum_q[CNT_RIGHT_DISC])) ||
	                   ((|sum_q[CNT_RIGHT_CLIP]) && (|sum_q[CNT_LEFT_DISC]));

	always_comb begin
		if (left_hit && right_hit) begin
			res_class = CLASS_TWO_SIDE;
		end else if (left_hit || right_hit) begin
			res_class = crossed ? CLASS_ONE_HALF : CLASS_ONE_SIDE;
		end else begin
			res_class = CLASS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (fire) begin
			if (flush_s1) begin
				open_q <= 1'b0;
			end else if (admit_s1) begin
				open_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !flush_s1 && admit_s1) begin
			last_pos_q <= pos_s1;
			if (chain) begin
				sum_q <= sum_sat;
				if (evidence_s1 > best_ev_q) begin
					best_ev_q  <= evidence_s1;
					best_pos_q <= pos_s1;
				end
			end else begin
				chrom_q    <= chrom_s1;
				best_ev_q  <= evidence_s1;
				best_pos_q <= (evidence_s1 != '0) ? pos_s1 : '0;
				sum_q      <= cnt_s1;
			end
		end
	end

endmodule

// ===== rtl/sswc_result_reg.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: result register
// Holds one cluster result until the sink takes it.
// ----------------------------------------------------------------------------
module sswc_result_reg
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   res_valid,
	input  logic [CHROM_WIDTH-1:0] res_chrom,
	input  logic [POS_WIDTH-1:0]   res_position,
	input  logic [COUNT_WIDTH-1:0] res_sum [NUM_COUNTS-2],
	input  logic [COUNT_WIDTH:0]   res_polya,
	input  support_class_t         res_class,
	output logic                   advance,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHROM_WIDTH-1:0] out_chrom,
	output logic [POS_WIDTH-1:0]   out_position,
	output logic [COUNT_WIDTH-1:0] out_sum [NUM_COUNTS-2],
	output logic [COUNT_WIDTH:0]   out_polya,
	output support_class_t         out_class
);

	// room for a new result when empty or when the held one transfers now
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_chrom    <= res_chrom;
			out_position <= res_position;
			out_sum      <= res_sum;
			out_polya    <= res_polya;
			out_class    <= res_class;
		end
	end

endmodule

// ===== rtl/sorted_site_window_clusterer_top.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: top level
// Gap-based single-linkage clustering of sorted evidence sites.
// ----------------------------------------------------------------------------
// The block takes one site or end-of-data marker per cycle, unless a stalled
// result holds it back, and returns a cluster result at most one per item. A
// transfer on the site channel is registered in the input stage; from there
// the cluster core folds it into the open cluster (one window compare, six
// saturating adds and a best evidence compare) and, when the item closes a
// cluster that passes the keep thresholds, loads the result register. A result
// therefore passes through the input stage and the result register on its way
// to the cluster channel. Sustained rate is one item per clock while the sink
// takes results, set by the cluster core updating its state for each item as
// it fires. Site ready drops only while a result sits untaken in the result
// register and the input stage is occupied. Write configuration only while
// the block is idle; writes to unmapped indexes are dropped.
module sorted_site_window_clusterer_top
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int CHROM_WIDTH = CHROM_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  cfg_index_t                wr_index,
	input  logic [CFG_DATA_WIDTH-1:0] wr_data,
	sswc_site_if.sink                 site,
	sswc_cluster_if.source            cluster
);

	cfg_t                   cfg;

	// site payload gathered into the count array
	logic [COUNT_WIDTH-1:0] site_cnt [NUM_COUNTS];

	// input stage
	logic                   valid_s1;
	logic                   flush_s1;
	logic                   admit_s1;
	logic [CHROM_WIDTH-1:0] chrom_s1;
	logic [POS_WIDTH-1:0]   pos_s1;
	logic [COUNT_WIDTH-1:0] cnt_s1 [NUM_COUNTS];
	logic [COUNT_WIDTH+1:0] evidence_s1;

	// core to result register
	logic                   advance;
	logic                   fire;
	logic                   res_valid;
	logic [CHROM_WIDTH-1:0] res_chrom;
	logic [POS_WIDTH-1:0]   res_position;
	logic [COUNT_WIDTH-1:0] res_sum [NUM_COUNTS-2];
	logic [COUNT_WIDTH:0]   res_polya;
	support_class_t         res_class;

	// result register outputs
	logic [COUNT_WIDTH-1:0] out_sum [NUM_COUNTS-2];
	support_class_t         out_class;

	assign site_cnt[CNT_LEFT_CLIP]   = site.left_clip;
	assign site_cnt[CNT_RIGHT_CLIP]  = site.right_clip;
	assign site_cnt[CNT_LEFT_DISC]   = site.left_disc;
	assign site_cnt[CNT_RIGHT_DISC]  = site.right_disc;
	assign site_cnt[CNT_LEFT_POLYA]  = site.polya_left;
	assign site_cnt[CNT_RIGHT_POLYA] = site.polya_right;

	sswc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sswc_site_stage #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.CHROM_WIDTH (CHROM_WIDTH)
	) u_site_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (site.valid),
		.in_ready    (site.ready),
		.operation   (site.operation),
		.chromosome  (site.chromosome),
		.position    (site.position),
		.cnt         (site_cnt),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.flush_s1    (flush_s1),
		.admit_s1    (admit_s1),
		.chrom_s1    (chrom_s1),
		.pos_s1      (pos_s1),
		.cnt_s1      (cnt_s1),
		.evidence_s1 (evidence_s1)
	);

	// the staged item updates the cluster state when the result side has room
	assign fire = valid_s1 && advance;

	sswc_cluster_core #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.CHROM_WIDTH (CHROM_WIDTH)
	) u_cluster_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.fire         (fire),
		.flush_s1     (flush_s1),
		.admit_s1     (admit_s1),
		.chrom_s1     (chrom_s1),
		.pos_s1       (pos_s1),
		.cnt_s1       (cnt_s1),
		.evidence_s1  (evidence_s1),
		.res_valid    (res_valid),
		.res_chrom    (res_chrom),
		.res_position (res_position),
		.res_sum      (res_sum),
		.res_polya    (res_polya),
		.res_class    (res_class)
	);

	sswc_result_reg #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.CHROM_WIDTH (CHROM_WIDTH)
	) u_result_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_chrom    (res_chrom),
		.res_position (res_position),
		.res_sum      (res_sum),
		.res_polya    (res_polya),
		.res_class    (res_class),
		.advance      (advance),
		.out_valid    (cluster.valid),
		.out_ready    (cluster.ready),
		.out_chrom    (cluster.out_chromosome),
		.out_position (cluster.rep_position),
		.out_sum      (out_sum),
		.out_polya    (cluster.polya_total),
		.out_class    (out_class)
	);

	assign cluster.left_clip_total  = out_sum[CNT_LEFT_CLIP];
	assign cluster.right_clip_total = out_sum[CNT_RIGHT_CLIP];
	assign cluster.left_disc_total  = out_sum[CNT_LEFT_DISC];
	assign cluster.right_disc_total = out_sum[CNT_RIGHT_DISC];
	assign cluster.support_class    = out_class;

endmodule

// ===== rtl/sswc_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted site window clusterer: port checker
// Assertions on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_site_window_clusterer_top_assert.svh"

module sswc_checker
	import sswc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   site_valid,
	input logic                   site_ready,
	input logic                   cluster_valid,
	input logic                   cluster_ready,
	input logic [POS_WIDTH-1:0]   rep_position,
	input logic [CLASS_WIDTH-1:0] support_class,
	input logic [COUNT_WIDTH-1:0] left_clip_total
);

	logic                                          site_xfer;
	logic                                          res_stall;
	logic [POS_WIDTH+CLASS_WIDTH+COUNT_WIDTH-1:0]  payload;

	assign site_xfer = site_valid && site_ready;
	assign res_stall = cluster_valid && !cluster_ready;
	assign payload   = {rep_position, support_class, left_clip_total};

	// a fresh result always follows a site transfer through the input stage and the result register
	`SSWC_ASSERT_IMPLIES(a_result_follows_site, clk, arst_n, $rose(cluster_valid), $past(site_xfer, 2), "orphan result")

	// sites are refused only while a result is held back
	`SSWC_ASSERT_IMPLIES(a_ready_unless_stalled, clk, arst_n, !res_stall, site_ready, "site ready low, result side free")

	`SSWC_ASSERT_NEXT(a_result_held, clk, arst_n, res_stall, cluster_valid, "stalled result dropped")

	`SSWC_ASSERT_NEXT(a_payload_held, clk, arst_n, res_stall, $stable(payload), "stalled result payload changed")

endmodule

bind sorted_site_window_clusterer_top sswc_checker #(
	.COUNT_WIDTH (COUNT_WIDTH)
) u_sswc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.site_valid      (site.valid),
	.site_ready      (site.ready),
	.cluster_valid   (cluster.valid),
	.cluster_ready   (cluster.ready),
	.rep_position    (cluster.rep_position),
	.support_class   (cluster.support_class),
	.left_clip_total (cluster.left_clip_total)
);
